[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds whenever antecedent holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/b32kd_pkg.sv]
`timescale 1ns / 1ps

package b32kd_pkg;

    localparam int MAX_BURST = 5;
    localparam int BURST_W   = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR    = 2'd2;
    localparam logic [1:0] STATUS_BAD_PADDING = 2'd3;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       byte_valid;
        logic       end_of_key;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic [BURST_W-1:0]            count;
        result_t [MAX_BURST-1:0]       items;
    } burst_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] value;
    } sym_t;

    // lenient alphabet: either case, and 0, 1, 8 read as O, L, B
    function automatic sym_t sym_decode(input logic [7:0] c);
        sym_t r;
        r.ok    = 1'b1;
        r.value = 5'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.value = 5'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.value = 5'(c - 8'h61);
        end
        else if (c >= 8'h32 && c <= 8'h37)
        begin
            r.value = 5'(c - 8'h32 + 8'd26);
        end
        else if (c == 8'h30)
        begin
            r.value = 5'd14;
        end
        else if (c == 8'h31)
        begin
            r.value = 5'd11;
        end
        else if (c == 8'h38)
        begin
            r.value = 5'd1;
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[hw/rtl/b32kd_result_fifo.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b32kd_result_fifo
    import b32kd_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  burst_t  burst,
    output logic    room,
    input  logic    push,
    input  logic    pop,
    output logic    not_empty,
    output result_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W:0]     fill_after;
    logic [BURST_W-1:0] push_count;
    logic               do_pop;

    assign not_empty  = (count_reg != '0);
    assign fill_after = {1'b0, count_reg} + (CNT_W + 1)'(burst.count);
    assign room       = (fill_after <= (CNT_W + 1)'(DEPTH));
    assign push_count = push ? burst.count : '0;
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_BURST; k++)
        begin
            if (BURST_W'(k) < push_count)
            begin
                mem[wr_ptr_reg + PTR_W'(k)] <= burst.items[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPLIES(a_push_room, clk, rst_n, push && burst.count != '0, room)
    `ASSERT_ALWAYS(a_ptr_gap, clk, rst_n,
        (count_reg == CNT_W'(DEPTH)) || (PTR_W'(count_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg)))

endmodule

[hw/rtl/base32_key_decoder.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Base32 key decoder: one key character is taken per cycle into an input register, checked
// and folded into the current group of eight; the eighth character of a group pushes up to
// five key bytes if no error was seen, and a final character that pushes no bytes pushes a
// status beat, into a result queue of FIFO_DEPTH entries. A result passes from the input
// register into the queue and reaches the output behind any beats already queued. Input is
// stalled only while the queue lacks room for the beats that the held character pushes, so
// with a free-running output the block sustains one character per cycle.
module base32_key_decoder
    import b32kd_pkg::*;
#(
    parameter int FIFO_DEPTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       symbol_valid,
    output logic       symbol_stall,
    input  logic [7:0] symbol,
    input  logic       final_symbol,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] key_byte,
    output logic       byte_valid,
    output logic       end_of_key,
    output logic [1:0] status
);

    logic        in_full_reg;
    logic [7:0]  sym_reg;
    logic        fin_reg;

    logic [4:0]  gv_reg [8];
    logic [2:0]  group_position_reg;
    logic [2:0]  group_position_next;
    logic        padding_started_reg;
    logic        padding_started_next;
    logic [2:0]  pad_start_reg;
    logic [2:0]  pad_start_next;
    logic        padded_done_reg;
    logic        padded_done_next;
    logic [1:0]  first_error_reg;
    logic [1:0]  first_error_next;

    logic        room;
    logic        fire;
    logic        accept;
    sym_t        dec;
    logic [4:0]  val;
    logic [1:0]  err;
    logic        emit;
    logic [1:0]  final_status;
    logic [7:0]  bytes [MAX_BURST];
    logic [BURST_W-1:0] nbytes;
    burst_t      burst;
    result_t     head;
    logic        not_empty;

    assign fire         = in_full_reg && room;
    assign symbol_stall = in_full_reg && !room;
    assign accept       = symbol_valid && !symbol_stall;
    assign dec          = sym_decode(sym_reg);

    always_comb
    begin
        err                  = STATUS_OK;
        val                  = 5'd0;
        padding_started_next = padding_started_reg;
        pad_start_next       = pad_start_reg;
        padded_done_next     = padded_done_reg;
        if (padding_started_reg || padded_done_reg)
        begin
            if (sym_reg != PAD_CHAR)
            begin
                err = STATUS_BAD_PADDING;
            end
        end
        else if (sym_reg == PAD_CHAR)
        begin
            if (group_position_reg == 3'd2 || group_position_reg == 3'd4 ||
                group_position_reg == 3'd5 || group_position_reg == 3'd7)
            begin
                padding_started_next = 1'b1;
                pad_start_next       = group_position_reg;
            end
            else
            begin
                err = STATUS_BAD_PADDING;
            end
        end
        else if (!dec.ok)
        begin
            err = STATUS_BAD_CHAR;
        end
        else
        begin
            val = dec.value;
        end

        first_error_next = first_error_reg;
        if (first_error_reg == STATUS_OK && err != STATUS_OK)
        begin
            first_error_next = err;
        end
        if (group_position_reg == 3'd7 && padding_started_next && !fin_reg)
        begin
            padded_done_next = 1'b1;
            if (first_error_next == STATUS_OK)
            begin
                first_error_next = STATUS_BAD_PADDING;
            end
        end
        group_position_next = group_position_reg + 3'd1;

        emit = (group_position_reg == 3'd7) && (first_error_next == STATUS_OK);

        if (!padding_started_next)
        begin
            nbytes = BURST_W'(5);
        end
        else
        begin
            case (pad_start_next)
                3'd2:    nbytes = BURST_W'(1);
                3'd4:    nbytes = BURST_W'(2);
                3'd5:    nbytes = BURST_W'(3);
                default: nbytes = BURST_W'(4);
            endcase
        end

        bytes[0] = {gv_reg[0], gv_reg[1][4:2]};
        bytes[1] = {gv_reg[1][1:0], gv_reg[2], gv_reg[3][4]};
        bytes[2] = {gv_reg[3][3:0], gv_reg[4][4:1]};
        bytes[3] = {gv_reg[4][0], gv_reg[5], gv_reg[6][4:3]};
        bytes[4] = {gv_reg[6][2:0], val};

        final_status = (group_position_reg != 3'd7) ? STATUS_BAD_LENGTH : first_error_next;

        burst.count = '0;
        for (int k = 0; k < MAX_BURST; k++)
        begin
            burst.items[k].key_byte   = emit ? bytes[k] : 8'd0;
            burst.items[k].byte_valid = emit;
            burst.items[k].end_of_key = 1'b0;
            burst.items[k].status     = STATUS_OK;
        end
        if (emit)
        begin
            burst.count = nbytes;
            if (fin_reg)
            begin
                for (int k = 0; k < MAX_BURST; k++)
                begin
                    if (BURST_W'(k + 1) == nbytes)
                    begin
                        burst.items[k].end_of_key = 1'b1;
                    end
                end
            end
        end
        else if (fin_reg)
        begin
            burst.count               = BURST_W'(1);
            burst.items[0].end_of_key = 1'b1;
            burst.items[0].status     = final_status;
        end

        // start the next key afresh
        if (fin_reg)
        begin
            group_position_next  = 3'd0;
            padding_started_next = 1'b0;
            pad_start_next       = 3'd0;
            padded_done_next     = 1'b0;
            first_error_next     = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg <= symbol;
            fin_reg <= final_symbol;
        end
        if (fire)
        begin
            gv_reg[group_position_reg] <= val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg         <= 1'b0;
            group_position_reg  <= 3'd0;
            padding_started_reg <= 1'b0;
            pad_start_reg       <= 3'd0;
            padded_done_reg     <= 1'b0;
            first_error_reg     <= STATUS_OK;
        end
        else
        begin
            if (accept)
            begin
                in_full_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_full_reg <= 1'b0;
            end
            if (fire)
            begin
                group_position_reg  <= group_position_next;
                padding_started_reg <= padding_started_next;
                pad_start_reg       <= pad_start_next;
                padded_done_reg     <= padded_done_next;
                first_error_reg     <= first_error_next;
            end
        end
    end

    b32kd_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .burst     (burst),
        .room      (room),
        .push      (fire),
        .pop       (!result_stall),
        .not_empty (not_empty),
        .head      (head)
    );

    assign result_valid = not_empty;
    assign key_byte     = head.key_byte;
    assign byte_valid   = head.byte_valid;
    assign end_of_key   = head.end_of_key;
    assign status       = head.status;

    `ASSERT_IMPLIES(a_byte_status_ok, clk, rst_n, result_valid && byte_valid,
        status == STATUS_OK)
    `ASSERT_IMPLIES(a_status_on_end, clk, rst_n, result_valid && !end_of_key,
        status == STATUS_OK && byte_valid)
    `ASSERT_IMPLIES(a_no_bytes_after_error, clk, rst_n,
        fire && first_error_reg != STATUS_OK, burst.count == '0 || fin_reg)

endmodule

[test/base32_key_decoder_chk.sv]
`timescale 1ns / 1ps

module base32_key_decoder_chk
    import b32kd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       symbol_valid,
    input  logic       symbol_stall,
    input  logic [7:0] symbol,
    input  logic       final_symbol,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [7:0] key_byte,
    input  logic       byte_valid,
    input  logic       end_of_key,
    input  logic [1:0] status,
    output int         failures,
    output int         pending,
    output int         keys_done,
    output int         bytes_done,
    output logic [3:0] status_seen
);

    logic [4:0] grp_val [8];
    logic [2:0] grp_pos;
    logic       pad_on;
    logic [2:0] pad_at;
    logic       pad_group_done;
    logic [1:0] first_fault;
    result_t    owed_beats [$];
    int         beats_seen;

    initial
    begin
        failures    = 0;
        pending     = 0;
        keys_done   = 0;
        bytes_done  = 0;
        status_seen = '0;
        beats_seen  = 0;
    end

    // bit 5 flags a base32 symbol, bits 4:0 carry its value
    function automatic logic [5:0] char_to_quint(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return {1'b1, 5'(c - "A")};
        end
        if (c >= "a" && c <= "z")
        begin
            return {1'b1, 5'(c - "a")};
        end
        if (c >= "2" && c <= "7")
        begin
            return {1'b1, 5'(c - "2" + 26)};
        end
        if (c == "0")
        begin
            return {1'b1, 5'd14};
        end
        if (c == "1")
        begin
            return {1'b1, 5'd11};
        end
        if (c == "8")
        begin
            return {1'b1, 5'd1};
        end
        return 6'd0;
    endfunction

    task automatic clear_key();
        foreach (grp_val[i])
        begin
            grp_val[i] = 5'd0;
        end
        grp_pos        = 3'd0;
        pad_on         = 1'b0;
        pad_at         = 3'd0;
        pad_group_done = 1'b0;
        first_fault    = STATUS_OK;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic fin);
        logic [2:0] pos;
        logic [1:0] fault;
        logic [5:0] q;
        logic [4:0] v [8];
        logic [7:0] kb [5];
        logic [1:0] st;
        int         nbytes;
        result_t    beat;
        pos    = grp_pos;
        fault  = STATUS_OK;
        q      = 6'd0;
        nbytes = 0;
        if (pad_on || pad_group_done)
        begin
            if (c != PAD_CHAR)
            begin
                fault = STATUS_BAD_PADDING;
            end
        end
        else if (c == PAD_CHAR)
        begin
            if (pos == 3'd2 || pos == 3'd4 || pos == 3'd5 || pos == 3'd7)
            begin
                pad_on = 1'b1;
                pad_at = pos;
            end
            else
            begin
                fault = STATUS_BAD_PADDING;
            end
        end
        else
        begin
            q = char_to_quint(c);
            if (!q[5])
            begin
                fault = STATUS_BAD_CHAR;
            end
        end
        grp_val[pos] = q[4:0];
        if (first_fault == STATUS_OK && fault != STATUS_OK)
        begin
            first_fault = fault;
        end
        if (pos == 3'd7 && pad_on && !fin)
        begin
            pad_group_done = 1'b1;
            if (first_fault == STATUS_OK)
            begin
                first_fault = STATUS_BAD_PADDING;
            end
        end
        grp_pos = pos + 3'd1;
        st = (pos != 3'd7) ? STATUS_BAD_LENGTH : first_fault;
        if (pos == 3'd7 && first_fault == STATUS_OK)
        begin
            v = grp_val;
            kb[0] = {v[0], v[1][4:2]};
            kb[1] = {v[1][1:0], v[2], v[3][4]};
            kb[2] = {v[3][3:0], v[4][4:1]};
            kb[3] = {v[4][0], v[5], v[6][4:3]};
            kb[4] = {v[6][2:0], v[7]};
            if (!pad_on)
            begin
                nbytes = 5;
            end
            else
            begin
                case (pad_at)
                    3'd2:    nbytes = 1;
                    3'd4:    nbytes = 2;
                    3'd5:    nbytes = 3;
                    default: nbytes = 4;
                endcase
            end
            for (int i = 0; i < nbytes; i++)
            begin
                beat.key_byte   = kb[i];
                beat.byte_valid = 1'b1;
                beat.end_of_key = fin && (i == nbytes - 1);
                beat.status     = STATUS_OK;
                owed_beats.push_back(beat);
            end
        end
        if (fin)
        begin
            if (nbytes == 0)
            begin
                beat.key_byte   = 8'd0;
                beat.byte_valid = 1'b0;
                beat.end_of_key = 1'b1;
                beat.status     = st;
                owed_beats.push_back(beat);
            end
            clear_key();
        end
    endtask

    task automatic check_beat();
        result_t want;
        beats_seen++;
        if (owed_beats.size() == 0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("beat %0d: unexpected result byte %h valid %b end %b status %0d",
                         beats_seen, key_byte, byte_valid, end_of_key, status);
            end
            return;
        end
        want = owed_beats.pop_front();
        if (key_byte !== want.key_byte || byte_valid !== want.byte_valid ||
            end_of_key !== want.end_of_key || status !== want.status)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("beat %0d: expected %h v%b e%b s%0d, got %h v%b e%b s%0d",
                         beats_seen, want.key_byte, want.byte_valid, want.end_of_key,
                         want.status, key_byte, byte_valid, end_of_key, status);
            end
        end
        if (want.byte_valid)
        begin
            bytes_done++;
        end
        if (want.end_of_key)
        begin
            keys_done++;
            status_seen[want.status] = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_key();
            owed_beats.delete();
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_beat();
            end
            if (symbol_valid && !symbol_stall)
            begin
                decode_char(symbol, final_symbol);
            end
            pending = owed_beats.size();
        end
    end

endmodule

[test/base32_key_decoder_tb.sv]
`timescale 1ns / 1ps

module base32_key_decoder_tb;
    import b32kd_pkg::*;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       symbol_valid = 1'b0;
    logic [7:0] symbol       = 8'd0;
    logic       final_symbol = 1'b0;
    logic       result_stall = 1'b0;
    logic       symbol_stall;
    logic       result_valid;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       end_of_key;
    logic [1:0] status;

    int         failures;
    int         pending;
    int         keys_done;
    int         bytes_done;
    logic [3:0] status_seen;

    int         chars_sent   = 0;
    int         keys_sent    = 0;
    logic       tx_calm      = 1'b0;
    logic       rx_calm      = 1'b0;
    int         rx_mode_left = 0;
    int         stall_left   = 0;
    logic       res_taken    = 1'b0;
    logic [7:0] key_chars [$];

    base32_key_decoder uut (.*);

    base32_key_decoder_chk chk (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("base32_key_decoder_tb: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        res_taken <= result_valid && !result_stall;
    end

    // hold off the result side after each beat, with calm stretches now and then
    always @(negedge clk)
    begin
        if (res_taken)
        begin
            if (rx_mode_left == 0)
            begin
                rx_calm      = ($urandom_range(0, 3) == 0);
                rx_mode_left = $urandom_range(20, 60);
            end
            rx_mode_left--;
            stall_left = rx_calm ? 0 : $urandom_range(0, 8);
        end
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    function automatic logic is_key_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "2" && c <= "7") || c == "0" || c == "1" || c == "8";
    endfunction

    function automatic logic [7:0] key_char();
        int v;
        v = $urandom_range(0, 31);
        if (v >= 26)
        begin
            return 8'("2" + v - 26);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            if (v == 14)
            begin
                return "0";
            end
            if (v == 11)
            begin
                return "1";
            end
            if (v == 1)
            begin
                return "8";
            end
        end
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v);
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (is_key_char(c) || c == PAD_CHAR);
        return c;
    endfunction

    function automatic int pick_pad_start();
        case ($urandom_range(0, 3))
            0:       return 2;
            1:       return 4;
            2:       return 5;
            default: return 7;
        endcase
    endfunction

    // pad_start of 8 gives a group with no padding
    task automatic add_group(input int pad_start);
        for (int i = 0; i < 8; i++)
        begin
            key_chars.push_back(i < pad_start ? key_char() : PAD_CHAR);
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            symbol_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        symbol_valid <= 1'b1;
        symbol       <= c;
        final_symbol <= fin;
        @(posedge clk);
        while (symbol_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_key();
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < key_chars.size(); i++)
        begin
            send_char(key_chars[i], i == key_chars.size() - 1);
            chars_sent++;
        end
        keys_sent++;
        key_chars.delete();
    endtask

    initial
    begin
        int n;
        int p;
        int base;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        key_chars = '{"A", "Z", "a", "z", "2", "7", "0", "1"};
        send_key();
        key_chars = '{"M", "E", PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
        send_key();
        key_chars = '{8'h00};
        send_key();
        key_chars = '{"Q", "R", "S", 8'h7B, "T", "U", "V", 8'hFF};
        send_key();

        while (chars_sent < 465)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    n = $urandom_range(1, 3);
                    for (int g = 0; g < n - 1; g++)
                    begin
                        add_group(8);
                    end
                    add_group($urandom_range(0, 1) ? 8 : pick_pad_start());
                end
                5:
                begin
                    add_group($urandom_range(0, 1) ? 8 : pick_pad_start());
                    if ($urandom_range(0, 1))
                    begin
                        repeat ($urandom_range(1, 7)) void'(key_chars.pop_back());
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 7)) key_chars.push_back(key_char());
                    end
                end
                6:
                begin
                    repeat ($urandom_range(1, 2)) add_group(8);
                    key_chars[$urandom_range(0, key_chars.size() - 1)] = junk_char();
                end
                7:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        repeat ($urandom_range(0, 1)) add_group(8);
                        case ($urandom_range(0, 3))
                            0:       add_group(0);
                            1:       add_group(1);
                            2:       add_group(3);
                            default: add_group(6);
                        endcase
                    end
                    else
                    begin
                        case ($urandom_range(0, 2))
                            0:       p = 2;
                            1:       p = 4;
                            default: p = 5;
                        endcase
                        add_group(p);
                        base = key_chars.size() - 8;
                        key_chars[base + $urandom_range(p + 1, 7)] = key_char();
                    end
                end
                8:
                begin
                    add_group(pick_pad_start());
                    add_group($urandom_range(0, 1) ? 8 : pick_pad_start());
                end
                default:
                begin
                    repeat ($urandom_range(1, 12))
                    begin
                        key_chars.push_back($urandom_range(0, 3) == 0 ? PAD_CHAR
                                                                     : 8'($urandom_range(0, 255)));
                    end
                end
            endcase
            send_key();
        end

        symbol_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);

        $display("summary: %0d characters in %0d keys, %0d key bytes and %0d key ends checked",
                 chars_sent, keys_sent, bytes_done, keys_done);
        $display("summary: final statuses seen (bad padding, bad char, bad length, ok) = %b",
                 status_seen);
        if (failures == 0)
        begin
            $display("base32_key_decoder_tb: PASS");
        end
        else
        begin
            $display("base32_key_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
